FILE: design/dcbds_pkg.sv
package dcbds_pkg;

    localparam int MAX_COMMANDS  = 32;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int IDX_W         = $clog2(MAX_COMMANDS);
    localparam int CNT_W         = $clog2(MAX_COMMANDS + 1);
    localparam int SUM_W         = 34;
    localparam int ADDR_W        = 3;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] STAT_PUSHED   = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW = 3'd1;
    localparam logic [2:0] STAT_CLEARED  = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_EMIT     = 3'd4;

    localparam logic REG_TRI_CODE = 1'b0;
    localparam logic REG_SORT_EN  = 1'b1;

    typedef struct packed {
        logic [7:0]               cmd_type;
        logic [31:0]              depth_a;
        logic [31:0]              depth_b;
        logic [31:0]              depth_c;
        logic [PAYLOAD_WIDTH-1:0] payload;
        logic signed [SUM_W-1:0]  sum;
    } entry_t;

endpackage

FILE: design/draw_command_buffer_depth_sort_top.sv
// Channel    Direction  Handshake                      Payload
// command    in         start high while busy is low   action, cmd_type, depth_a..c, cmd_payload
// result     out        result_valid for one cycle     status, out_type, out_depth_a..c,
//                                                      out_payload, last_of_run
// config     in/out     APB, psel & penable & pwrite   paddr, pwdata, prdata
//
// A push or an overflow passes the push state, which registers its result; a clear or
// an empty flush gives its result in the cycle after the transfer.
// A flush with sorting on first insertion-sorts each run of entries whose type matches the
// tri code, one read and compare step at a time, then reads one entry a cycle to emit.
// Reset clears the fill count and the sequencer; entry storage holds no reset value.
// The receiver cannot stall, so results leave as soon as they are formed.
module draw_command_buffer_depth_sort_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [7:0]                   cmd_type,
    input  logic signed [31:0]           depth_a,
    input  logic signed [31:0]           depth_b,
    input  logic signed [31:0]           depth_c,
    input  logic [63:0]                  cmd_payload,
    output logic                         result_valid,
    output logic [2:0]                   status,
    output logic [7:0]                   out_type,
    output logic signed [31:0]           out_depth_a,
    output logic signed [31:0]           out_depth_b,
    output logic signed [31:0]           out_depth_c,
    output logic [63:0]                  out_payload,
    output logic                         last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcbds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dcbds_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUSH  = 4'd1;
    localparam logic [3:0] S_RD_I  = 4'd2;
    localparam logic [3:0] S_KEY   = 4'd3;
    localparam logic [3:0] S_RD_J  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_PLACE = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    entry_t           key_reg, key_next;
    entry_t           in_reg;
    logic             emit_pend_reg, emit_pend_next;
    logic             emit_last_reg, emit_last_next;
    logic [7:0]       tri_code_reg;
    logic             sort_en_reg;

    logic             result_valid_reg;
    logic [2:0]       status_reg;
    logic [7:0]       out_type_reg;
    logic [31:0]      out_depth_a_reg, out_depth_b_reg, out_depth_c_reg;
    logic [63:0]      out_payload_reg;
    logic             last_of_run_reg;

    entry_t           mem [MAX_COMMANDS];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             plain_valid;
    logic [2:0]       plain_status;
    logic             advance;
    logic             cfg_write;
    logic             tri_hit;
    logic             deeper;
    logic [SUM_W-1:0] push_sum;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SORT_EN) ? {31'd0, sort_en_reg} : {24'd0, tri_code_reg};
    assign busy      = (state_reg != S_IDLE);

    // The shared datapath: one three-way adder for pushes and one signed comparator for the sort.
    assign push_sum = SUM_W'($signed(in_reg.depth_a)) + SUM_W'($signed(in_reg.depth_b))
                    + SUM_W'($signed(in_reg.depth_c));
    assign tri_hit  = (rd_data_reg.cmd_type == tri_code_reg);
    assign deeper   = ($signed(rd_data_reg.sum) < $signed(key_reg.sum));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        emit_pend_next = 1'b0;
        emit_last_next = 1'b0;
        plain_valid    = 1'b0;
        plain_status   = STAT_PUSHED;
        advance        = 1'b0;
        rd_addr        = i_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            state_next = S_PUSH;
                        end
                        ACT_CLEAR:
                        begin
                            fill_next    = '0;
                            plain_valid  = 1'b1;
                            plain_status = STAT_CLEARED;
                        end
                        ACT_FLUSH:
                        begin
                            if (fill_reg == '0)
                            begin
                                plain_valid  = 1'b1;
                                plain_status = STAT_EMPTY;
                            end
                            else if (sort_en_reg && (fill_reg >= CNT_W'(2)))
                            begin
                                i_next     = IDX_W'(1);
                                state_next = S_RD_I;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                plain_valid = 1'b1;
                state_next  = S_IDLE;
                if (fill_reg == CNT_W'(MAX_COMMANDS))
                begin
                    plain_status = STAT_OVERFLOW;
                end
                else
                begin
                    plain_status = STAT_PUSHED;
                    wr_en        = 1'b1;
                    wr_addr      = fill_reg[IDX_W-1:0];
                    wr_data      = in_reg;
                    wr_data.sum  = push_sum;
                    fill_next    = fill_reg + CNT_W'(1);
                end
            end
            S_RD_I:
            begin
                rd_addr    = i_reg;
                state_next = S_KEY;
            end
            S_KEY:
            begin
                if (tri_hit)
                begin
                    key_next   = rd_data_reg;
                    j_next     = i_reg;
                    state_next = S_RD_J;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_RD_J:
            begin
                rd_addr    = j_reg - IDX_W'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (tri_hit && deeper)
                begin
                    wr_data    = rd_data_reg;
                    j_next     = j_reg - IDX_W'(1);
                    state_next = (j_reg == IDX_W'(1)) ? S_PLACE : S_RD_J;
                end
                else
                begin
                    wr_data = key_reg;
                    advance = 1'b1;
                end
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = key_reg;
                advance = 1'b1;
            end
            S_EMIT:
            begin
                rd_addr        = k_reg;
                emit_pend_next = 1'b1;
                if ((CNT_W'(k_reg) + CNT_W'(1)) == fill_reg)
                begin
                    emit_last_next = 1'b1;
                    state_next     = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                fill_next  = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if ((CNT_W'(i_reg) + CNT_W'(1)) >= fill_reg)
            begin
                k_next     = '0;
                state_next = S_EMIT;
            end
            else
            begin
                i_next     = i_reg + IDX_W'(1);
                state_next = S_RD_I;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            emit_pend_reg    <= 1'b0;
            emit_last_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            tri_code_reg     <= 8'd0;
            sort_en_reg      <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            emit_pend_reg    <= emit_pend_next;
            emit_last_reg    <= emit_last_next;
            result_valid_reg <= plain_valid || emit_pend_reg;
            if (cfg_write)
            begin
                if (paddr[2] == REG_SORT_EN)
                begin
                    sort_en_reg <= pwdata[0];
                end
                else
                begin
                    tri_code_reg <= pwdata[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (start && !busy)
        begin
            in_reg.cmd_type <= cmd_type;
            in_reg.depth_a  <= depth_a;
            in_reg.depth_b  <= depth_b;
            in_reg.depth_c  <= depth_c;
            in_reg.payload  <= cmd_payload[PAYLOAD_WIDTH-1:0];
            in_reg.sum      <= '0;
        end
        if (plain_valid)
        begin
            status_reg      <= plain_status;
            out_type_reg    <= 8'd0;
            out_depth_a_reg <= 32'd0;
            out_depth_b_reg <= 32'd0;
            out_depth_c_reg <= 32'd0;
            out_payload_reg <= 64'd0;
            last_of_run_reg <= 1'b1;
        end
        else if (emit_pend_reg)
        begin
            status_reg      <= STAT_EMIT;
            out_type_reg    <= rd_data_reg.cmd_type;
            out_depth_a_reg <= rd_data_reg.depth_a;
            out_depth_b_reg <= rd_data_reg.depth_b;
            out_depth_c_reg <= rd_data_reg.depth_c;
            out_payload_reg <= 64'(rd_data_reg.payload);
            last_of_run_reg <= emit_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_type     = out_type_reg;
    assign out_depth_a  = out_depth_a_reg;
    assign out_depth_b  = out_depth_b_reg;
    assign out_depth_c  = out_depth_c_reg;
    assign out_payload  = out_payload_reg;
    assign last_of_run  = last_of_run_reg;

endmodule

FILE: design/dcbds_checker.sv
module dcbds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  action,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic [7:0]  out_type,
    input logic [63:0] out_payload,
    input logic        last_of_run
);
    import dcbds_pkg::*;

    // A result that is not an emitted entry carries zero fields and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STAT_EMIT))
            |-> (last_of_run && (out_type == 8'd0) && (out_payload == 64'd0)))
        else $error("plain result with non-zero fields or open run");

    // Emitted entries of one flush leave in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == STAT_EMIT) && !last_of_run)
            |=> (result_valid && (status == STAT_EMIT)))
        else $error("gap inside a flush");

    // A clear transfer is answered in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_CLEAR)) |=> (result_valid && (status == STAT_CLEARED)))
        else $error("clear not answered");

    // A push transfer is answered with pushed or overflow after the push state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_PUSH))
            |=> ##1 (result_valid && ((status == STAT_PUSHED) || (status == STAT_OVERFLOW))))
        else $error("push not answered");

endmodule

bind draw_command_buffer_depth_sort_top dcbds_checker u_dcbds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .result_valid (result_valid),
    .status       (status),
    .out_type     (out_type),
    .out_payload  (out_payload),
    .last_of_run  (last_of_run)
);

FILE: tb/sv/tb_draw_command_buffer_depth_sort_top.sv
`timescale 1ns / 100ps

module tb_draw_command_buffer_depth_sort_top;
    import dcbds_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 56;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  ctype;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [63:0] payload;
    } draw_cmd_t;

    typedef struct packed {
        logic [7:0]               ctype;
        logic [31:0]              a;
        logic [31:0]              b;
        logic [31:0]              c;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } stored_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  ctype;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [63:0] payload;
        logic        last;
    } draw_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          action = '0;
    logic [7:0]          cmd_type = '0;
    logic signed [31:0]  depth_a = '0;
    logic signed [31:0]  depth_b = '0;
    logic signed [31:0]  depth_c = '0;
    logic [63:0]         cmd_payload = '0;
    logic                result_valid;
    logic [2:0]          status;
    logic [7:0]          out_type;
    logic signed [31:0]  out_depth_a;
    logic signed [31:0]  out_depth_b;
    logic signed [31:0]  out_depth_c;
    logic [63:0]         out_payload;
    logic                last_of_run;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    draw_command_buffer_depth_sort_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .cmd_type     (cmd_type),
        .depth_a      (depth_a),
        .depth_b      (depth_b),
        .depth_c      (depth_c),
        .cmd_payload  (cmd_payload),
        .result_valid (result_valid),
        .status       (status),
        .out_type     (out_type),
        .out_depth_a  (out_depth_a),
        .out_depth_b  (out_depth_b),
        .out_depth_c  (out_depth_c),
        .out_payload  (out_payload),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    draw_cmd_t    command_queue[$];
    draw_result_t results_due[$];
    draw_cmd_t    cur_cmd;

    stored_cmd_t  slots[MAX_COMMANDS];
    int           fill = 0;
    logic [7:0]   tri_code = 8'd0;
    logic         sort_on = 1'b1;

    int unsigned  issued_count = 0;
    int unsigned  accepted_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           queued_items = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string describe(draw_result_t r);
        return $sformatf("status=%0d type=%02h a=%08h b=%08h c=%08h payload=%016h last=%0b",
                         r.status, r.ctype, r.a, r.b, r.c, r.payload, r.last);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("Mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic logic signed [SUM_W-1:0] depth_total(stored_cmd_t s);
        logic signed [SUM_W-1:0] t;
        t = $signed(s.a);
        t = t + $signed(s.b);
        t = t + $signed(s.c);
        return t;
    endfunction

    // Works out the results of one command and updates the buffer image.
    task automatic buffer_command(input draw_cmd_t cmd);
        draw_result_t            r;
        stored_cmd_t             key;
        logic signed [SUM_W-1:0] key_sum;
        int                      i;
        int                      j;
        r = '0;
        r.last = 1'b1;
        case (cmd.action)
            ACT_PUSH:
            begin
                if (fill >= MAX_COMMANDS)
                begin
                    r.status = STAT_OVERFLOW;
                end
                else
                begin
                    slots[fill].ctype = cmd.ctype;
                    slots[fill].a = cmd.a;
                    slots[fill].b = cmd.b;
                    slots[fill].c = cmd.c;
                    slots[fill].payload = cmd.payload[PAYLOAD_WIDTH-1:0];
                    fill++;
                    r.status = STAT_PUSHED;
                end
                results_due.push_back(r);
            end
            ACT_CLEAR:
            begin
                fill = 0;
                r.status = STAT_CLEARED;
                results_due.push_back(r);
            end
            ACT_FLUSH:
            begin
                if (fill == 0)
                begin
                    r.status = STAT_EMPTY;
                    results_due.push_back(r);
                end
                else
                begin
                    if (sort_on)
                    begin
                        for (i = 1; i < fill; i++)
                        begin
                            key = slots[i];
                            if (key.ctype != tri_code)
                                continue;
                            key_sum = depth_total(key);
                            j = i;
                            while (j > 0 && slots[j-1].ctype == tri_code &&
                                   depth_total(slots[j-1]) < key_sum)
                            begin
                                slots[j] = slots[j-1];
                                j--;
                            end
                            slots[j] = key;
                        end
                    end
                    for (i = 0; i < fill; i++)
                    begin
                        r.status = STAT_EMIT;
                        r.ctype = slots[i].ctype;
                        r.a = slots[i].a;
                        r.b = slots[i].b;
                        r.c = slots[i].c;
                        r.payload = 64'(slots[i].payload);
                        r.last = (i == fill - 1);
                        results_due.push_back(r);
                    end
                    fill = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!start || accepted_count == issued_count))
        begin
            if (command_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cur_cmd = command_queue.pop_front();
                action <= cur_cmd.action;
                cmd_type <= cur_cmd.ctype;
                depth_a <= cur_cmd.a;
                depth_b <= cur_cmd.b;
                depth_c <= cur_cmd.c;
                cmd_payload <= cur_cmd.payload;
                start <= 1'b1;
                issued_count++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            buffer_command(cur_cmd);
            accepted_count++;
        end
    end

    always @(posedge clk)
    begin : result_check
        draw_result_t seen;
        draw_result_t want;
        if (rst_n && result_valid)
        begin
            seen = {status, out_type, out_depth_a, out_depth_b, out_depth_c,
                    out_payload, last_of_run};
            if (results_due.size() == 0)
            begin
                note_mismatch({"unexpected result ", describe(seen)});
            end
            else
            begin
                want = results_due.pop_front();
                if (seen !== want)
                begin
                    note_mismatch({"expected ", describe(want), " got ", describe(seen)});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic apb_transfer(input logic wr, input logic idx, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [31:0] want);
        logic [31:0] got;
        logic        bad;
        apb_transfer(1'b0, idx, 32'd0, got);
        if (idx == REG_TRI_CODE)
            bad = (got[7:0] !== want[7:0]);
        else
            bad = (got[0] !== want[0]);
        if (bad)
        begin
            note_mismatch($sformatf("register %0d read %08h, expected %08h", idx, got, want));
        end
    endtask

    task automatic set_register(input logic idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_transfer(1'b1, idx, value, unused);
        if (idx == REG_TRI_CODE)
            tri_code = value[7:0];
        else
            sort_on = value[0];
        check_register(idx, value);
    endtask

    task automatic queue_cmd(input logic [1:0] act, input logic [7:0] t, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] c,
                             input logic [63:0] p);
        draw_cmd_t cmd;
        cmd = {act, t, a, b, c, p};
        command_queue.push_back(cmd);
        if (act != ACT_UNUSED)
            queued_items++;
    endtask

    function automatic logic [31:0] pick_depth();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 32'($signed($urandom_range(0, 8)) - 4);
        if (roll < 60)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 99) < 70)
            return tri_code;
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return 64'hffff_ffff_ffff_ffff;
            1: return 64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_noise(input logic [1:0] act);
        queue_cmd(act, 8'($urandom), $urandom, $urandom, $urandom, {$urandom, $urandom});
    endtask

    task automatic queue_batch(input bit go_deep);
        int roll;
        int n;
        int k;
        roll = $urandom_range(0, 99);
        if (!go_deep && roll < 10)
        begin
            case ($urandom_range(0, 3))
                0, 1: queue_noise(ACT_UNUSED);
                2: queue_noise(ACT_CLEAR);
                default: queue_noise(ACT_FLUSH);
            endcase
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                queue_noise(ACT_CLEAR);
            if (go_deep || roll >= 93)
                n = $urandom_range(30, 35);
            else if (roll < 14)
                n = 0;
            else
                n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    queue_noise(ACT_UNUSED);
                queue_cmd(ACT_PUSH, pick_type(), pick_depth(), pick_depth(), pick_depth(),
                          pick_payload());
            end
            queue_noise(ACT_FLUSH);
        end
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || issued_count != accepted_count || start ||
               results_due.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_register(REG_TRI_CODE, 32'd0);
        check_register(REG_SORT_EN, 32'd1);

        sender_idle_pct = 31;
        queue_noise(ACT_FLUSH);
        queue_noise(ACT_CLEAR);
        queue_cmd(ACT_UNUSED, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  64'hffff_ffff_ffff_ffff);
        queue_cmd(ACT_PUSH, 8'h00, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  64'hffff_ffff_ffff_ffff);
        queue_cmd(ACT_PUSH, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'd0);
        queue_cmd(ACT_PUSH, 8'h00, 32'd0, 32'd0, 32'd0, 64'h0123_4567_89ab_cdef);
        queue_cmd(ACT_PUSH, 8'h00, 32'd1, 32'hffff_ffff, 32'd0, 64'hfedc_ba98_7654_3210);
        queue_cmd(ACT_PUSH, 8'hff, 32'd100, 32'd200, 32'd300, 64'haaaa_5555_aaaa_5555);
        queue_cmd(ACT_PUSH, 8'h00, 32'hffff_fffb, 32'd2, 32'd1, 64'h5555_aaaa_5555_aaaa);
        queue_cmd(ACT_PUSH, 8'h00, 32'd7, 32'd7, 32'd7, 64'd1);
        queue_cmd(ACT_PUSH, 8'h00, 32'd7, 32'd7, 32'd7, 64'd2);
        queue_cmd(ACT_PUSH, 8'h00, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 64'd3);
        queue_noise(ACT_FLUSH);
        queue_noise(ACT_FLUSH);
        queue_cmd(ACT_PUSH, 8'h00, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 64'd4);
        queue_noise(ACT_CLEAR);
        queue_noise(ACT_FLUSH);
        queue_cmd(ACT_PUSH, 8'h01, 32'h8000_0000, 32'd5, 32'h7fff_ffff, 64'd5);
        queue_noise(ACT_FLUSH);
        wait_drained();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    set_register(REG_TRI_CODE, 32'd0);
                    set_register(REG_SORT_EN, 32'd1);
                end
                1:
                begin
                    set_register(REG_TRI_CODE, 32'd255);
                    set_register(REG_SORT_EN, 32'd0);
                end
                2:
                begin
                    set_register(REG_TRI_CODE, 32'h5a);
                    set_register(REG_SORT_EN, 32'd1);
                end
                3:
                begin
                    set_register(REG_TRI_CODE, 32'($urandom_range(1, 254)));
                    set_register(REG_SORT_EN, 32'd1);
                end
                4:
                begin
                    set_register(REG_TRI_CODE, 32'd255);
                    set_register(REG_SORT_EN, 32'd1);
                end
                default:
                begin
                    set_register(REG_TRI_CODE, 32'd0);
                    set_register(REG_SORT_EN, 32'd0);
                end
            endcase
            sender_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 55 : 0;
            queued_items = 0;
            queue_batch(phase == 0 || phase == 3 || phase == 4);
            while (queued_items < PHASE_ITEMS)
                queue_batch(1'b0);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
